FILE: design/mean_shift_change_point_scan_assert.svh
// assertion macros shared by the scan checker
// every macro expects clk and arst_n in the scope where it is used
`ifndef MEAN_SHIFT_CHANGE_POINT_SCAN_ASSERT_SVH
`define MEAN_SHIFT_CHANGE_POINT_SCAN_ASSERT_SVH

// same-cycle implication
`define MSC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scan check failed");

// next-cycle implication
`define MSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scan check failed");

`endif

FILE: design/msc_pkg.sv
// shared types and constants of the mean shift change point scan
// no dependencies
package msc_pkg;

	localparam logic [31:0] CRIT_RESET = 32'd196608;
	localparam int MIN_SERIES = 3;

	typedef enum logic [3:0] {
		ST_LOAD, ST_HREQ, ST_HADD, ST_MH, ST_MH_WAIT, ST_MT, ST_MT_WAIT, ST_ACC,
		ST_DRAIN, ST_MUL, ST_MUL_WAIT, ST_CHECK, ST_TDIV_WAIT, ST_SQRT_WAIT,
		ST_UPDATE, ST_FINISH
	} state_t;

	typedef enum logic [1:0] {DIV_MH, DIV_MT, DIV_T} div_sel_t;
	typedef enum logic [2:0] {MUL_KN, MUL_N2, MUL_D1, MUL_D2, MUL_DEN} mul_op_t;
	typedef enum logic [1:0] {T_ZERO, T_SAT, T_ROOT} t_sel_t;

	typedef struct packed {
		logic     load;
		logic     scan_init;
		logic     head_rd;
		logic     head_add;
		logic     k_next;
		logic     div_start;
		div_sel_t div_sel;
		logic     mh_take;
		logic     mt_take;
		logic     acc_clear;
		logic     acc_issue;
		logic     mul_start;
		mul_op_t  mul_op;
		logic     mul_take;
		logic     sqrt_start;
		logic     t_set;
		t_sel_t   t_sel;
		logic     best_update;
		logic     out_short;
		logic     out_result;
	} cmd_t;

	typedef struct packed {
		logic short_series;
		logic div_busy;
		logic mul_busy;
		logic sqrt_busy;
		logic pipe_busy;
		logic i_last;
		logic k_last;
		logic acc_zero;
		logic saturate;
	} sts_t;

endpackage

FILE: design/msc_div.sv
// shared restoring divider, one quotient bit per cycle
// divisor arrives already shifted to the top quotient bit; no package use
module msc_div #(
	parameter int W  = 165,
	parameter int QW = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [W-1:0]          dividend,
	input  logic [W-1:0]          divisor_sh,
	input  logic [$clog2(QW+1)-1:0] nbits,
	output logic                  busy,
	output logic [QW-1:0]         quotient
);
	localparam int NW = $clog2(QW + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  dsh_q;
	logic [QW-1:0] quot_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic          ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - NW'(1);
			if (cnt_q == NW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dsh_q  <= divisor_sh;
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - dsh_q;
			quot_q <= {quot_q[QW-2:0], ge};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign busy     = busy_q;
	assign quotient = quot_q;

endmodule

FILE: design/msc_dp.sv
// datapath: sample store, sums, deviation pipeline, serial multiplier,
// divider, square root and result registers; uses msc_pkg and msc_div
module msc_dp #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  msc_pkg::cmd_t      cmd,
	output msc_pkg::sts_t      sts,
	input  logic signed [31:0] sample,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	output logic [31:0]        max_statistic,
	output logic [10:0]        change_index,
	output logic signed [32:0] shift,
	output logic               non_stationary,
	output logic               too_short
);
	import msc_pkg::*;

	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int AW   = $clog2(MAX_SAMPLES);
	localparam int SUMW = 32 + CW;
	localparam int ACCW = 66 + CW;
	localparam int DENW = ACCW + CW;
	localparam int NUMW = 3 * CW + 98;
	localparam int DVW  = (NUMW > DENW + 65) ? NUMW : DENW + 65;
	localparam int QW   = 64;
	localparam int NW   = $clog2(QW + 1);

	logic [31:0] mem_q [MAX_SAMPLES];
	logic [31:0] rd_q;
	logic [AW-1:0] rd_addr;

	logic [CW-1:0] count_q, count_nxt, n_q, k_q, i_q, nm1, km1, nk;
	logic full;
	logic signed [SUMW-1:0] total_q, head_q, sum_mt;
	logic [31:0] crit_q;

	// series load
	assign full      = count_q == CW'(MAX_SAMPLES);
	assign count_nxt = full ? count_q : count_q + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crit_q  <= CRIT_RESET;
		end else begin
			if (cmd.load)
				count_q <= cmd.scan_init || cmd.out_short ? '0 : count_nxt;
			if (cfg_we)
				crit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			mem_q[count_q[AW-1:0]] <= sample;
			total_q <= (count_q == '0 ? SUMW'(0) : total_q) + SUMW'(sample);
		end
		if (cmd.load)
			n_q <= count_nxt;
		if (cmd.head_rd || cmd.acc_issue)
			rd_q <= mem_q[rd_addr];
	end

	assign nm1     = n_q - CW'(1);
	assign km1     = k_q - CW'(1);
	assign nk      = n_q - k_q;
	assign rd_addr = cmd.acc_issue ? i_q[AW-1:0] : km1[AW-1:0];
	assign sum_mt  = total_q - head_q;

	// means through the shared divider
	logic signed [SUMW-1:0] mean_sum, mean_sum_neg;
	logic [CW-1:0]          mean_cnt;
	logic [SUMW-1:0]        mean_mag;
	logic [DVW-1:0]         num_q, div_dividend, div_divisor;
	logic [DENW-1:0]        den_q;
	logic [NW-1:0]          div_nbits;
	logic                   div_busy;
	logic [QW-1:0]          quot;
	logic [32:0]            mq, mq_neg;
	logic signed [32:0]     mh_q, mt_q;

	assign mean_sum     = (cmd.div_sel == DIV_MT) ? sum_mt : head_q;
	assign mean_cnt     = (cmd.div_sel == DIV_MT) ? nk : k_q;
	assign mean_sum_neg = -mean_sum;
	assign mean_mag     = mean_sum[SUMW-1] ? mean_sum_neg : mean_sum;

	always_comb begin
		if (cmd.div_sel == DIV_T) begin
			div_dividend = num_q;
			div_divisor  = DVW'(den_q) << (QW - 1);
			div_nbits    = NW'(QW);
		end else begin
			div_dividend = DVW'(mean_mag) + DVW'(mean_cnt >> 1);
			div_divisor  = DVW'(mean_cnt) << (SUMW - 1);
			div_nbits    = NW'(SUMW);
		end
	end

	msc_div #(.W(DVW), .QW(QW)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (cmd.div_start),
		.dividend   (div_dividend),
		.divisor_sh (div_divisor),
		.nbits      (div_nbits),
		.busy       (div_busy),
		.quotient   (quot)
	);

	assign mq     = quot[32:0];
	assign mq_neg = -mq;

	always_ff @(posedge clk) begin
		if (cmd.scan_init)
			head_q <= '0;
		else if (cmd.head_add)
			head_q <= head_q + SUMW'(signed'(rd_q));
		if (cmd.mh_take)
			mh_q <= head_q[SUMW-1] ? mq_neg : mq;
		if (cmd.mt_take)
			mt_q <= sum_mt[SUMW-1] ? mq_neg : mq;
	end

	logic signed [33:0] d_w, d_neg_w;
	logic [32:0]        dabs;
	assign d_w     = {mt_q[32], mt_q} - {mh_q[32], mh_q};
	assign d_neg_w = -d_w;
	assign dabs    = d_w[33] ? d_neg_w[32:0] : d_w[32:0];

	// deviation pipeline: read, square, accumulate
	logic        acc_v_s1, acc_v_s2;
	logic [33:0] x34, dh, dt, dh_n, dt_n;
	logic [32:0] dh_abs, dt_abs;
	logic [65:0] sqh_s2, sqt_s2;
	logic [ACCW-1:0] acc_q;

	assign x34    = {rd_q[31], rd_q[31], rd_q};
	assign dh     = x34 - {mh_q[32], mh_q};
	assign dt     = x34 - {mt_q[32], mt_q};
	assign dh_n   = -dh;
	assign dt_n   = -dt;
	assign dh_abs = dh[33] ? dh_n[32:0] : dh[32:0];
	assign dt_abs = dt[33] ? dt_n[32:0] : dt[32:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_v_s1 <= 1'b0;
			acc_v_s2 <= 1'b0;
		end else begin
			acc_v_s1 <= cmd.acc_issue;
			acc_v_s2 <= acc_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sqh_s2 <= dh_abs * dh_abs;
		sqt_s2 <= dt_abs * dt_abs;
		if (cmd.acc_clear) begin
			acc_q <= '0;
			i_q   <= '0;
		end else begin
			if (acc_v_s2)
				acc_q <= acc_q + ACCW'(sqh_s2) + ACCW'(sqt_s2);
			if (cmd.acc_issue)
				i_q <= i_q + CW'(1);
		end
	end

	// shift-and-add multiplier, one bit of b a cycle
	logic [DVW-1:0] mul_a_q, prod_q, mul_a_in;
	logic [32:0]    mul_b_q, mul_b_in;
	logic [5:0]     mul_cnt_q;
	logic           mul_busy_q;

	always_comb begin
		unique case (cmd.mul_op)
			MUL_KN: begin
				mul_a_in = DVW'(k_q);
				mul_b_in = 33'(nk);
			end
			MUL_N2: begin
				mul_a_in = prod_q;
				mul_b_in = 33'(n_q - CW'(2));
			end
			MUL_D1, MUL_D2: begin
				mul_a_in = prod_q;
				mul_b_in = dabs;
			end
			MUL_DEN: begin
				mul_a_in = DVW'(acc_q);
				mul_b_in = 33'(n_q);
			end
			default: begin
				mul_a_in = '0;
				mul_b_in = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_cnt_q  <= '0;
		end else if (cmd.mul_start) begin
			mul_busy_q <= 1'b1;
			mul_cnt_q  <= 6'd33;
		end else if (mul_busy_q) begin
			mul_cnt_q <= mul_cnt_q - 6'd1;
			if (mul_cnt_q == 6'd1)
				mul_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mul_a_q <= mul_a_in;
			mul_b_q <= mul_b_in;
			prod_q  <= '0;
		end else if (mul_busy_q) begin
			if (mul_b_q[0])
				prod_q <= prod_q + mul_a_q;
			mul_a_q <= mul_a_q << 1;
			mul_b_q <= mul_b_q >> 1;
		end
		if (cmd.mul_take && cmd.mul_op == MUL_D2)
			num_q <= prod_q << 32;
		if (cmd.mul_take && cmd.mul_op == MUL_DEN)
			den_q <= prod_q[DENW-1:0];
	end

	// bitwise integer square root, 32 iterations
	logic [63:0] sq_v_q, sq_r_q, sq_bit_q, sq_try;
	logic [5:0]  sq_cnt_q;
	logic        sq_busy_q;

	assign sq_try = sq_r_q + sq_bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_cnt_q  <= '0;
		end else if (cmd.sqrt_start) begin
			sq_busy_q <= 1'b1;
			sq_cnt_q  <= 6'd32;
		end else if (sq_busy_q) begin
			sq_cnt_q <= sq_cnt_q - 6'd1;
			if (sq_cnt_q == 6'd1)
				sq_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sq_v_q   <= quot;
			sq_r_q   <= '0;
			sq_bit_q <= 64'd1 << 62;
		end else if (sq_busy_q) begin
			if (sq_v_q >= sq_try) begin
				sq_v_q <= sq_v_q - sq_try;
				sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	// split bookkeeping and best so far
	logic [31:0]        t_q, best_stat_q;
	logic [CW-1:0]      best_split_q;
	logic signed [33:0] best_shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_stat_q  <= '0;
			best_split_q <= '0;
		end else if (cmd.scan_init) begin
			best_stat_q  <= '0;
			best_split_q <= '0;
		end else if (cmd.best_update && (k_q == CW'(1) || t_q >= best_stat_q)) begin
			best_stat_q  <= t_q;
			best_split_q <= k_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init)
			k_q <= CW'(1);
		else if (cmd.k_next)
			k_q <= k_q + CW'(1);
		if (cmd.t_set) begin
			unique case (cmd.t_sel)
				T_ZERO:  t_q <= '0;
				T_SAT:   t_q <= '1;
				T_ROOT:  t_q <= sq_r_q[31:0];
				default: t_q <= '0;
			endcase
		end
		if (cmd.scan_init)
			best_shift_q <= '0;
		else if (cmd.best_update && (k_q == CW'(1) || t_q >= best_stat_q))
			best_shift_q <= d_w;
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_short) begin
			max_statistic  <= '0;
			change_index   <= '0;
			shift          <= '0;
			non_stationary <= 1'b0;
			too_short      <= 1'b1;
		end else if (cmd.out_result) begin
			max_statistic  <= best_stat_q;
			change_index   <= 11'(best_split_q);
			shift          <= best_shift_q[32:0];
			non_stationary <= best_stat_q > crit_q;
			too_short      <= 1'b0;
		end
	end

	assign sts.short_series = count_nxt < CW'(MIN_SERIES);
	assign sts.div_busy     = div_busy;
	assign sts.mul_busy     = mul_busy_q;
	assign sts.sqrt_busy    = sq_busy_q;
	assign sts.pipe_busy    = acc_v_s1 || acc_v_s2;
	assign sts.i_last       = i_q == nm1;
	assign sts.k_last       = k_q == nm1;
	assign sts.acc_zero     = acc_q == '0;
	assign sts.saturate     = num_q >= (DVW'(den_q) << QW);

endmodule

FILE: design/msc_ctrl.sv
// controller: sequences load, per-split means, deviation pass,
// statistic and result beat; uses msc_pkg
module msc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          last_sample,
	input  logic          out_stall,
	output logic          in_stall,
	output logic          out_valid,
	output msc_pkg::cmd_t cmd,
	input  msc_pkg::sts_t sts
);
	import msc_pkg::*;

	state_t  state_q, state_d;
	mul_op_t mul_op_q, mul_op_d;
	logic    out_valid_q;
	logic    accept;

	assign in_stall  = (state_q != ST_LOAD) || (out_valid_q && last_sample);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			mul_op_q    <= MUL_KN;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			mul_op_q <= mul_op_d;
			if (cmd.out_short || cmd.out_result)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d  = state_q;
		mul_op_d = mul_op_q;
		unique case (state_q)
			ST_LOAD:
				if (accept && last_sample && !sts.short_series)
					state_d = ST_HREQ;
			ST_HREQ:    state_d = ST_HADD;
			ST_HADD:    state_d = ST_MH;
			ST_MH:      state_d = ST_MH_WAIT;
			ST_MH_WAIT: if (!sts.div_busy) state_d = ST_MT;
			ST_MT:      state_d = ST_MT_WAIT;
			ST_MT_WAIT: if (!sts.div_busy) state_d = ST_ACC;
			ST_ACC:     if (sts.i_last) state_d = ST_DRAIN;
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d  = ST_MUL;
					mul_op_d = MUL_KN;
				end
			end
			ST_MUL:     state_d = ST_MUL_WAIT;
			ST_MUL_WAIT: begin
				if (!sts.mul_busy) begin
					unique case (mul_op_q)
						MUL_KN:  begin mul_op_d = MUL_N2; state_d = ST_MUL; end
						MUL_N2:  begin mul_op_d = MUL_D1; state_d = ST_MUL; end
						MUL_D1:  begin mul_op_d = MUL_D2; state_d = ST_MUL; end
						MUL_D2:  begin mul_op_d = MUL_DEN; state_d = ST_MUL; end
						default: state_d = ST_CHECK;
					endcase
				end
			end
			ST_CHECK: begin
				priority if (sts.acc_zero || sts.saturate)
					state_d = ST_UPDATE;
				else
					state_d = ST_TDIV_WAIT;
			end
			ST_TDIV_WAIT: if (!sts.div_busy) state_d = ST_SQRT_WAIT;
			ST_SQRT_WAIT: if (!sts.sqrt_busy) state_d = ST_UPDATE;
			ST_UPDATE:    state_d = sts.k_last ? ST_FINISH : ST_HREQ;
			ST_FINISH:    if (!out_valid_q || !out_stall) state_d = ST_LOAD;
			default:      state_d = ST_LOAD;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.mul_op = mul_op_q;
		unique case (state_q)
			ST_LOAD: begin
				cmd.load = accept;
				if (accept && last_sample) begin
					cmd.out_short = sts.short_series;
					cmd.scan_init = !sts.short_series;
				end
			end
			ST_HREQ: cmd.head_rd = 1'b1;
			ST_HADD: cmd.head_add = 1'b1;
			ST_MH: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_MH;
			end
			ST_MH_WAIT: cmd.mh_take = !sts.div_busy;
			ST_MT: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_MT;
			end
			ST_MT_WAIT: begin
				cmd.mt_take   = !sts.div_busy;
				cmd.acc_clear = !sts.div_busy;
			end
			ST_ACC:      cmd.acc_issue = 1'b1;
			ST_MUL:      cmd.mul_start = 1'b1;
			ST_MUL_WAIT: cmd.mul_take = !sts.mul_busy;
			ST_CHECK: begin
				cmd.div_sel = DIV_T;
				priority if (sts.acc_zero) begin
					cmd.t_set = 1'b1;
					cmd.t_sel = T_ZERO;
				end else if (sts.saturate) begin
					cmd.t_set = 1'b1;
					cmd.t_sel = T_SAT;
				end else begin
					cmd.div_start = 1'b1;
				end
			end
			ST_TDIV_WAIT: cmd.sqrt_start = !sts.div_busy;
			ST_SQRT_WAIT: begin
				cmd.t_set = !sts.sqrt_busy;
				cmd.t_sel = T_ROOT;
			end
			ST_UPDATE: begin
				cmd.best_update = 1'b1;
				cmd.k_next      = !sts.k_last;
			end
			ST_FINISH: cmd.out_result = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

endmodule

FILE: design/mean_shift_change_point_scan.sv
// Mean shift change point scan. Samples load one per cycle into an internal
// store while in_stall is low; the beat marked last_sample closes the series.
// A series of fewer than three samples returns a too_short beat right away.
// Otherwise the input stalls while every split k = 1 .. N-1 is scanned: per
// split two head/tail means come from a serial divider, a pass over all N
// stored samples through the single memory read port sums the squared
// deviations, a shift-add multiplier forms numerator and denominator in five
// products, then the divider and the square root give the statistic (zero for
// a zero deviation sum, all ones on overflow). The result beat then waits in
// an output register while the next series loads. The critical value from
// cfg_wdata is compared with the maximum statistic when the beat is formed.
module mean_shift_change_point_scan #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] sample,
	input  logic               last_sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        max_statistic,
	output logic [10:0]        change_index,
	output logic signed [32:0] shift,
	output logic               non_stationary,
	output logic               too_short,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata
);
	import msc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	msc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_sample (last_sample),
		.out_stall   (out_stall),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.cmd         (cmd),
		.sts         (sts)
	);

	msc_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.sample         (sample),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.max_statistic  (max_statistic),
		.change_index   (change_index),
		.shift          (shift),
		.non_stationary (non_stationary),
		.too_short      (too_short)
	);

endmodule

FILE: design/msc_checker.sv
// port-level checks of the scan block, attached to the top level by bind
// depends on mean_shift_change_point_scan_assert.svh
`include "mean_shift_change_point_scan_assert.svh"

module msc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [31:0]        max_statistic,
	input logic [10:0]        change_index,
	input logic signed [32:0] shift,
	input logic               non_stationary,
	input logic               too_short
);

	// a waiting beat is not dropped
	`MSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// a short series reports nothing but the flag
	`MSC_ASSERT_IMPL(a_short_zero, out_valid && too_short,
		max_statistic == 32'd0 && change_index == 11'd0 && shift == 33'sd0)

	`MSC_ASSERT_IMPL(a_short_flag, out_valid && too_short, !non_stationary)

	// the flag needs a statistic above a non-negative threshold
	`MSC_ASSERT_IMPL(a_flag_stat, out_valid && non_stationary, max_statistic != 32'd0)

endmodule

bind mean_shift_change_point_scan msc_checker u_msc_checker (.*);
